// File: hdl/smas_pkg.sv
`default_nettype none

package smas_pkg;

    // Default largest matrix side.
    localparam int MAX_DIM_DEF = 8;

    // Fixed field widths.
    localparam int ELEM_W = 16;
    localparam int RES_W  = 35;
    localparam int CFG_W  = 4;
    localparam int REG_W  = 2;

    // Operation codes held in the operation register.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_MUL   = 2'd2,
        OP_MUL_T = 2'd3
    } smas_op_t;

    // Configuration register indexes.
    localparam logic [REG_W-1:0] REG_ROWS = 2'd0;
    localparam logic [REG_W-1:0] REG_COLS = 2'd1;
    localparam logic [REG_W-1:0] REG_OP   = 2'd2;

    // Marks that travel with each pair of operands read from the stores.
    typedef struct packed {
        logic first_term;
        logic last_term;
        logic last_elem;
    } smas_tag_t;

endpackage

`default_nettype wire

// File: hdl/smas_ram.sv
`default_nettype none

module smas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/smas_seq.sv
`default_nettype none

module smas_seq
    import smas_pkg::*;
#(
    parameter  int MAX_DIM = MAX_DIM_DEF,
    localparam int DEPTH   = MAX_DIM * MAX_DIM,
    localparam int AW      = $clog2(DEPTH),
    localparam int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             launch,
    input  wire smas_op_t         op,
    input  wire logic [DIM_W-1:0] rows,
    input  wire logic [DIM_W-1:0] cols,
    input  wire logic [AW:0]      n,
    output logic      [AW-1:0]    a_addr,
    output logic      [AW-1:0]    b_addr,
    output logic                  active,
    output logic                  rd_valid,
    output smas_tag_t             rd_tag
);

    localparam int IW = $clog2(MAX_DIM);

    logic            active_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   j_reg;
    logic [IW-1:0]   k_reg;
    logic [AW-1:0]   a_row_reg;
    logic [AW-1:0]   a_addr_reg;
    logic [AW-1:0]   b_base_reg;
    logic [AW-1:0]   b_addr_reg;
    logic            rd_valid_reg;
    smas_tag_t       rd_tag_reg;

    logic            mul;
    logic [IW-1:0]   rows_m1;
    logic [IW-1:0]   cols_m1;
    logic [AW-1:0]   n_m1;
    logic [AW-1:0]   cols_w;
    logic [AW-1:0]   b_kstep;
    logic [AW-1:0]   b_jstep;
    logic            k_last;
    logic            j_last;
    logic            i_last;
    logic            elem_last;
    logic            done;
    smas_tag_t       tag;

    assign mul     = (op == OP_MUL) || (op == OP_MUL_T);
    assign rows_m1 = IW'(rows - 1'b1);
    assign cols_m1 = IW'(cols - 1'b1);
    assign n_m1    = AW'(n - 1'b1);
    assign cols_w  = AW'(cols);

    // A plain product walks B down a column; the transposed one walks along a row.
    assign b_kstep = (op == OP_MUL) ? cols_w : AW'(1);
    assign b_jstep = (op == OP_MUL) ? AW'(1) : cols_w;

    assign k_last    = !mul || (k_reg == cols_m1);
    assign j_last    = (j_reg == rows_m1);
    assign i_last    = (i_reg == rows_m1);
    assign elem_last = mul ? (j_last && i_last) : (a_addr_reg == n_m1);
    assign done      = k_last && elem_last;

    assign tag.first_term = !mul || (k_reg == '0);
    assign tag.last_term  = k_last;
    assign tag.last_elem  = elem_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            a_row_reg    <= '0;
            a_addr_reg   <= '0;
            b_base_reg   <= '0;
            b_addr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            rd_tag_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= active_reg;
            rd_tag_reg   <= tag;
            if (launch)
            begin
                active_reg <= 1'b1;
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
                a_row_reg  <= '0;
                a_addr_reg <= '0;
                b_base_reg <= '0;
                b_addr_reg <= '0;
            end
            else if (active_reg)
            begin
                if (done)
                begin
                    active_reg <= 1'b0;
                end
                if (!mul)
                begin
                    a_addr_reg <= a_addr_reg + 1'b1;
                    b_addr_reg <= b_addr_reg + 1'b1;
                end
                else if (!k_last)
                begin
                    k_reg      <= k_reg + 1'b1;
                    a_addr_reg <= a_addr_reg + 1'b1;
                    b_addr_reg <= b_addr_reg + b_kstep;
                end
                else
                begin
                    k_reg <= '0;
                    if (!j_last)
                    begin
                        j_reg      <= j_reg + 1'b1;
                        b_base_reg <= b_base_reg + b_jstep;
                        b_addr_reg <= b_base_reg + b_jstep;
                        a_addr_reg <= a_row_reg;
                    end
                    else
                    begin
                        j_reg      <= '0;
                        b_base_reg <= '0;
                        b_addr_reg <= '0;
                        i_reg      <= i_reg + 1'b1;
                        a_row_reg  <= a_row_reg + cols_w;
                        a_addr_reg <= a_row_reg + cols_w;
                    end
                end
            end
        end
    end

    assign a_addr   = a_addr_reg;
    assign b_addr   = b_addr_reg;
    assign active   = active_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_tag   = rd_tag_reg;

endmodule

`default_nettype wire

// File: hdl/smas_datapath.sv
`default_nettype none

module smas_datapath
    import smas_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_valid,
    input  wire smas_tag_t                rd_tag,
    input  wire logic signed [ELEM_W-1:0] a_data,
    input  wire logic signed [ELEM_W-1:0] b_data,
    input  wire smas_op_t                 op,
    input  wire logic                     err_pulse,
    output logic                          pipe_busy,
    output logic                          result_valid,
    output logic signed [RES_W-1:0]       result_value,
    output logic                          last_result,
    output logic                          shape_error
);

    logic                      valid2_reg;
    smas_tag_t                 tag2_reg;
    logic signed [RES_W-1:0]   term2_reg;
    logic signed [RES_W-1:0]   acc_reg;
    logic                      out_valid_reg;
    logic signed [RES_W-1:0]   out_value_reg;
    logic                      out_last_reg;
    logic                      out_err_reg;

    logic signed [2*ELEM_W-1:0] prod;
    logic signed [ELEM_W:0]     a_ext;
    logic signed [ELEM_W:0]     b_ext;
    logic signed [ELEM_W:0]     sum_ab;
    logic signed [RES_W-1:0]    term;
    logic signed [RES_W-1:0]    acc_sum;

    assign prod  = a_data * b_data;
    assign a_ext = (ELEM_W + 1)'(a_data);
    assign b_ext = (ELEM_W + 1)'(b_data);

    always_comb
    begin
        sum_ab = (op == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
        case (op)
            OP_MUL, OP_MUL_T: term = RES_W'(prod);
            default:          term = RES_W'(sum_ab);
        endcase
    end

    // Each output element is the sum of its terms; the first term restarts it.
    assign acc_sum = tag2_reg.first_term ? term2_reg : (acc_reg + term2_reg);

    always_ff @(posedge clk)
    begin
        term2_reg <= term;
        if (valid2_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (err_pulse)
        begin
            out_value_reg <= '0;
        end
        else if (valid2_reg && tag2_reg.last_term)
        begin
            out_value_reg <= acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg    <= 1'b0;
            tag2_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            valid2_reg    <= rd_valid;
            tag2_reg      <= rd_tag;
            out_valid_reg <= err_pulse || (valid2_reg && tag2_reg.last_term);
            out_last_reg  <= err_pulse || tag2_reg.last_elem;
            out_err_reg   <= err_pulse;
        end
    end

    assign pipe_busy    = valid2_reg;
    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign shape_error  = out_err_reg;

endmodule

`default_nettype wire

// File: hdl/small_matrix_add_sub_multiply_core.sv
// Channel   Signals                                       Handshake
// ------    -------------------------------------------   ----------------------------
// input     element_value                                 start high while busy is low
// result    result_value, last_result, shape_error        result_valid, one cycle each
// config    cfg_index, cfg_data                           cfg_valid and cfg_ready
//
// Loading takes one element per cycle while busy is low; A and B go into two
// single-port-write memories. The element that completes B launches a compute burst.
// Busy stays high through the burst, which runs on one multiply-accumulate unit fed by
// one read port on each memory. The final result shows in the first cycle with busy low,
// so the next element can be taken at the same edge as that result.
// A plain product on a non-square shape launches nothing and yields one flagged result,
// registered through the error pulse and the output register, after the element that
// completes B is taken.
// Reset clears the shape registers to one, the operation to add and the load to A.
// The result receiver cannot stall; results leave in order, one per strobe.
`default_nettype none

module small_matrix_add_sub_multiply_core
    import smas_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [ELEM_W-1:0] element_value,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [REG_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    output logic                          result_valid,
    output logic signed [RES_W-1:0]       result_value,
    output logic                          last_result,
    output logic                          shape_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // Configuration registers.
    logic [CFG_W-1:0] rows_cfg_reg;
    logic [CFG_W-1:0] cols_cfg_reg;
    smas_op_t         op_reg;

    // Load position: the element index inside the current matrix and which one.
    logic [AW-1:0]    load_addr_reg;
    logic             load_b_reg;
    logic             err_pulse_reg;

    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [AW:0]      n;
    logic             accept;
    logic             cfg_write;
    logic             shape_write;
    logic             load_end;
    logic             launch;
    logic             shape_bad;
    logic             seq_active;
    logic             rd_valid;
    smas_tag_t        rd_tag;
    logic [AW-1:0]    a_raddr;
    logic [AW-1:0]    b_raddr;
    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;
    logic             pipe_busy;

    // Out-of-range dimensions: zero counts as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    assign rows = clamp_dim(rows_cfg_reg);
    assign cols = clamp_dim(cols_cfg_reg);
    assign n    = (AW + 1)'(rows) * (AW + 1)'(cols);

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign shape_write = cfg_write && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));
    assign busy        = seq_active || rd_valid || pipe_busy;
    assign accept      = start && !busy;
    assign load_end    = ({1'b0, load_addr_reg} + 1'b1) == n;

    // A plain product is only defined for square matrices.
    assign shape_bad = (op_reg == OP_MUL) && (rows != cols);
    assign launch    = accept && load_b_reg && load_end && !shape_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= CFG_W'(1);
            cols_cfg_reg  <= CFG_W'(1);
            op_reg        <= OP_ADD;
            load_addr_reg <= '0;
            load_b_reg    <= 1'b0;
            err_pulse_reg <= 1'b0;
        end
        else
        begin
            err_pulse_reg <= accept && load_b_reg && load_end && shape_bad;
            // A new shape restarts the load with A.
            if (shape_write)
            begin
                load_addr_reg <= '0;
                load_b_reg    <= 1'b0;
            end
            else if (accept)
            begin
                if (load_end)
                begin
                    load_addr_reg <= '0;
                    load_b_reg    <= !load_b_reg;
                end
                else
                begin
                    load_addr_reg <= load_addr_reg + 1'b1;
                end
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ROWS:
                    begin
                        rows_cfg_reg <= cfg_data;
                    end
                    REG_COLS:
                    begin
                        cols_cfg_reg <= cfg_data;
                    end
                    REG_OP:
                    begin
                        op_reg <= smas_op_t'(cfg_data[1:0]);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    smas_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (accept && !load_b_reg),
        .waddr (load_addr_reg),
        .wdata (element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    smas_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (accept && load_b_reg),
        .waddr (load_addr_reg),
        .wdata (element_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // The sequencer walks the stores; writes never overlap its reads because
    // loading is held off while busy.
    smas_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (launch),
        .op       (op_reg),
        .rows     (rows),
        .cols     (cols),
        .n        (n),
        .a_addr   (a_raddr),
        .b_addr   (b_raddr),
        .active   (seq_active),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag)
    );

    smas_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_valid     (rd_valid),
        .rd_tag       (rd_tag),
        .a_data       ($signed(a_rdata)),
        .b_data       ($signed(b_rdata)),
        .op           (op_reg),
        .err_pulse    (err_pulse_reg),
        .pipe_busy    (pipe_busy),
        .result_valid (result_valid),
        .result_value (result_value),
        .last_result  (last_result),
        .shape_error  (shape_error)
    );

    // The final result of a burst leaves with the pipeline already drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> !busy)
        else $error("last result while compute still in flight");

    // A burst only ends by delivering its final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last_result)
        else $error("compute burst ended without a final result");

    // The shape-error item is a lone, zero-valued final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && shape_error |-> last_result && (result_value == '0) && !busy)
        else $error("malformed shape-error result");

    // Launching a burst always raises busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        launch |=> busy)
        else $error("compute burst did not start");

endmodule

`default_nettype wire
